/* hdl/hrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request framer package
// Word types, phase and field-mode encodings, status and fault codes, and the
// header-name prefixes matched against each header line.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int HEADER_BYTES_W = 12;
   localparam int BODY_BYTES_W   = 14;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [3:0]                fault;
      logic [HEADER_BYTES_W-1:0] header_bytes;
      logic [BODY_BYTES_W-1:0]   body_bytes;
   } rsp_word_type;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_BODY,
      PH_DONE,
      PH_REJ
   } phase_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SPACE,
      MODE_DIGIT
   } mode_type;

   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   localparam logic [1:0] STATUS_COLLECT  = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [1:0] STATUS_REJECT   = 2'd2;

   localparam logic [3:0] FAULT_NONE     = 4'd0;
   localparam logic [3:0] FAULT_NUL      = 4'd1;
   localparam logic [3:0] FAULT_FULL     = 4'd2;
   localparam logic [3:0] FAULT_TE       = 4'd3;
   localparam logic [3:0] FAULT_DUP      = 4'd4;
   localparam logic [3:0] FAULT_EMPTY    = 4'd5;
   localparam logic [3:0] FAULT_DIGIT    = 4'd6;
   localparam logic [3:0] FAULT_TOOLARGE = 4'd7;
   localparam logic [3:0] FAULT_EXCESS   = 4'd8;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] BLANK_NONE  = 2'd0;
   localparam logic [1:0] BLANK_CR    = 2'd1;
   localparam logic [1:0] BLANK_CRLF  = 2'd2;
   localparam logic [1:0] BLANK_CRLFCR = 2'd3;

   localparam logic [1:0] FLAG_TE = 2'b01;
   localparam logic [1:0] FLAG_CL = 2'b10;

   localparam logic [4:0] TE_LEN  = 5'd18;
   localparam logic [4:0] CL_LEN  = 5'd15;
   localparam logic [4:0] POS_MAX = 5'd31;

   localparam logic [8*18-1:0] TE_PREFIX = "transfer-encoding:";
   localparam logic [8*15-1:0] CL_PREFIX = "content-length:";

   function automatic logic [7:0] te_char(input logic [4:0] pos);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < 18; i++) begin
         if (pos == 5'(i)) begin
            c = TE_PREFIX[8*(17-i) +: 8];
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] pos);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < 15; i++) begin
         if (pos == 5'(i)) begin
            c = CL_PREFIX[8*(14-i) +: 8];
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) ? 8'(c + 8'd32) : c;
   endfunction

endpackage

/* hdl/http_request_framer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request framer core
// Frames one HTTP/1.1 request from a byte stream using Content-Length.
//
// req_ channel: one word per received byte (req_type selects data or
// restart). rsp_ channel: one result word for every request word, in order,
// with status, first fault, header size and parsed body length.
// A word is held in the input register, then moves to the result register,
// where its result waits until it is taken. One word a cycle is sustained
// while rsp_stall is low; the per-byte header checks, digit accumulate and
// size compare all sit between those two registers.
// Reset (synchronous) empties both registers and returns the framer to
// collecting headers with all counters cleared; a restart word does the same
// to the framing state and answers with an all-zero result.
// When rsp_stall holds a waiting result, the input register still takes one
// more word; req_stall rises only once both registers are full.
// ----------------------------------------------------------------------------
module http_request_framer_core #(
   parameter int BUFFER_BYTES   = 2048,
   parameter int MAX_BODY_DIV10 = 819
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hrf_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hrf_pkg::rsp_word_type rsp_data
);

   localparam int CW = $clog2(BUFFER_BYTES);
   localparam int LW = $clog2(MAX_BODY_DIV10 * 10 + 10);
   localparam int TW = ((CW > LW) ? CW : LW) + 1;

   localparam logic [CW-1:0] FULL_AT    = CW'(BUFFER_BYTES - 1);
   localparam logic [TW-1:0] TOTAL_MAX  = TW'(BUFFER_BYTES);
   localparam logic [LW-1:0] DIV10_MAX  = LW'(MAX_BODY_DIV10);

   typedef struct packed {
      logic             past_first_line;
      logic [4:0]       line_position;
      logic [1:0]       name_flags;
      hrf_pkg::mode_type mode;
      logic             cl_seen;
      logic [LW-1:0]    length_value;
      logic [3:0]       first_fault;
   } line_state_type;

   localparam line_state_type LINE_RESET = '{
      past_first_line: 1'b0,
      line_position:   5'd0,
      name_flags:      hrf_pkg::FLAG_TE | hrf_pkg::FLAG_CL,
      mode:            hrf_pkg::MODE_NONE,
      cl_seen:         1'b0,
      length_value:    '0,
      first_fault:     hrf_pkg::FAULT_NONE
   };

   function automatic line_state_type line_char(input line_state_type s,
                                                input logic [7:0] c);
      line_state_type r;
      logic [7:0]     lc;
      r  = s;
      lc = hrf_pkg::to_lower(c);
      if (r.past_first_line && r.first_fault == hrf_pkg::FAULT_NONE) begin
         if (r.mode == hrf_pkg::MODE_NONE) begin
            if (r.line_position < hrf_pkg::TE_LEN && r.name_flags[0] &&
                lc != hrf_pkg::te_char(r.line_position)) begin
               r.name_flags[0] = 1'b0;
            end
            if (r.line_position < hrf_pkg::CL_LEN && r.name_flags[1] &&
                lc != hrf_pkg::cl_char(r.line_position)) begin
               r.name_flags[1] = 1'b0;
            end
            if (r.line_position < hrf_pkg::POS_MAX) begin
               r.line_position = r.line_position + 5'd1;
            end
            if (r.line_position == hrf_pkg::TE_LEN && r.name_flags[0]) begin
               r.first_fault = hrf_pkg::FAULT_TE;
            end else if (r.line_position == hrf_pkg::CL_LEN && r.name_flags[1]) begin
               if (r.cl_seen) begin
                  r.first_fault = hrf_pkg::FAULT_DUP;
               end else begin
                  r.cl_seen = 1'b1;
                  r.mode    = hrf_pkg::MODE_SPACE;
               end
            end
         end else if (!(r.mode == hrf_pkg::MODE_SPACE && c == hrf_pkg::CHAR_SPACE)) begin
            r.mode = hrf_pkg::MODE_DIGIT;
            if (c < hrf_pkg::CHAR_ZERO || c > hrf_pkg::CHAR_NINE ||
                r.length_value > DIV10_MAX) begin
               r.first_fault = hrf_pkg::FAULT_DIGIT;
            end else begin
               r.length_value = LW'(({3'b000, r.length_value} << 3) +
                                    ({3'b000, r.length_value} << 1) +
                                    (LW+3)'(c[3:0]));
            end
         end
      end
      return r;
   endfunction

   function automatic line_state_type line_end(input line_state_type s);
      line_state_type r;
      r = s;
      if (!r.past_first_line) begin
         r.past_first_line = 1'b1;
      end else if (r.first_fault == hrf_pkg::FAULT_NONE &&
                   r.mode == hrf_pkg::MODE_SPACE) begin
         r.first_fault = hrf_pkg::FAULT_EMPTY;
      end
      r.line_position = 5'd0;
      r.name_flags    = hrf_pkg::FLAG_TE | hrf_pkg::FLAG_CL;
      r.mode          = hrf_pkg::MODE_NONE;
      return r;
   endfunction

   // pipeline registers
   logic                  in_vld_ff, in_vld_in;
   hrf_pkg::req_word_type in_word_ff;
   logic                  out_vld_ff, out_vld_in;
   hrf_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                  step_en;
   logic                  req_take;

   // framing state
   hrf_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         blank_ff, blank_in;
   logic               pending_cr_ff, pending_cr_in;
   logic [CW-1:0]      header_end_ff, header_end_in;
   line_state_type     line_ff, line_in;

   logic [7:0]         b;
   logic               found;
   logic [TW-1:0]      total;

   assign step_en   = in_vld_ff && !(out_vld_ff && rsp_stall);
   assign req_stall = in_vld_ff && out_vld_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign b         = in_word_ff.rx_byte;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (step_en) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (step_en) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      blank_in      = blank_ff;
      pending_cr_in = pending_cr_ff;
      header_end_in = header_end_ff;
      line_in       = line_ff;
      found         = 1'b0;
      total         = TW'(header_end_ff) + TW'(line_ff.length_value);
      if (step_en) begin
         if (in_word_ff.req_type == hrf_pkg::REQ_RESTART) begin
            phase_in      = hrf_pkg::PH_HEAD;
            count_in      = '0;
            blank_in      = hrf_pkg::BLANK_NONE;
            pending_cr_in = 1'b0;
            header_end_in = '0;
            line_in       = LINE_RESET;
         end else begin
            case (phase_ff)
               hrf_pkg::PH_HEAD, hrf_pkg::PH_BODY: begin
                  if (b == hrf_pkg::CHAR_NUL) begin
                     phase_in            = hrf_pkg::PH_REJ;
                     line_in.first_fault = hrf_pkg::FAULT_NUL;
                  end else begin
                     count_in = count_ff + CW'(1);
                     if (phase_ff == hrf_pkg::PH_HEAD) begin
                        found = (blank_ff == hrf_pkg::BLANK_CRLFCR) &&
                                (b == hrf_pkg::CHAR_LF);
                        if (b == hrf_pkg::CHAR_CR) begin
                           blank_in = (blank_ff == hrf_pkg::BLANK_CRLF) ?
                                      hrf_pkg::BLANK_CRLFCR : hrf_pkg::BLANK_CR;
                        end else if (b == hrf_pkg::CHAR_LF &&
                                     blank_ff == hrf_pkg::BLANK_CR) begin
                           blank_in = hrf_pkg::BLANK_CRLF;
                        end else begin
                           blank_in = hrf_pkg::BLANK_NONE;
                        end
                        total = TW'(count_in) + TW'(line_ff.length_value);
                        if (found) begin
                           pending_cr_in = 1'b0;
                           header_end_in = count_in;
                           if (line_ff.first_fault != hrf_pkg::FAULT_NONE) begin
                              phase_in = hrf_pkg::PH_REJ;
                           end else if (total >= TOTAL_MAX) begin
                              phase_in            = hrf_pkg::PH_REJ;
                              line_in.first_fault = hrf_pkg::FAULT_TOOLARGE;
                           end else if (line_ff.length_value == '0) begin
                              phase_in = hrf_pkg::PH_DONE;
                           end else begin
                              phase_in = hrf_pkg::PH_BODY;
                           end
                        end else begin
                           if (pending_cr_ff) begin
                              if (b == hrf_pkg::CHAR_LF) begin
                                 pending_cr_in = 1'b0;
                                 line_in       = line_end(line_ff);
                              end else begin
                                 line_in = line_char(line_ff, hrf_pkg::CHAR_CR);
                                 if (b == hrf_pkg::CHAR_CR) begin
                                    pending_cr_in = 1'b1;
                                 end else begin
                                    pending_cr_in = 1'b0;
                                    line_in       = line_char(line_in, b);
                                 end
                              end
                           end else if (b == hrf_pkg::CHAR_CR) begin
                              pending_cr_in = 1'b1;
                           end else begin
                              line_in = line_char(line_ff, b);
                           end
                           if (count_in >= FULL_AT) begin
                              phase_in            = hrf_pkg::PH_REJ;
                              line_in.first_fault = hrf_pkg::FAULT_FULL;
                           end
                        end
                     end else if (TW'(count_in) == total) begin
                        phase_in = hrf_pkg::PH_DONE;
                     end
                  end
               end
               hrf_pkg::PH_DONE: begin
                  phase_in            = hrf_pkg::PH_REJ;
                  line_in.first_fault = hrf_pkg::FAULT_EXCESS;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // result word
   always_comb begin
      out_word_in = '0;
      case (phase_in)
         hrf_pkg::PH_DONE: begin
            out_word_in.status = hrf_pkg::STATUS_COMPLETE;
         end
         hrf_pkg::PH_REJ: begin
            out_word_in.status = hrf_pkg::STATUS_REJECT;
            out_word_in.fault  = line_in.first_fault;
         end
         default: begin
            out_word_in.status = hrf_pkg::STATUS_COLLECT;
         end
      endcase
      out_word_in.header_bytes = hrf_pkg::HEADER_BYTES_W'(header_end_in);
      if (header_end_in != '0 &&
          !(line_in.first_fault inside {[hrf_pkg::FAULT_TE:hrf_pkg::FAULT_DIGIT]})) begin
         out_word_in.body_bytes = hrf_pkg::BODY_BYTES_W'(line_in.length_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         phase_ff      <= hrf_pkg::PH_HEAD;
         count_ff      <= '0;
         blank_ff      <= hrf_pkg::BLANK_NONE;
         pending_cr_ff <= 1'b0;
         header_end_ff <= '0;
         line_ff       <= LINE_RESET;
      end else begin
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         blank_ff      <= blank_in;
         pending_cr_ff <= pending_cr_in;
         header_end_ff <= header_end_in;
         line_ff       <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
      if (step_en) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

endmodule
